>>> hw/rtl/acos_pkg.sv
// shared types and constants of the arc cosine pipeline
package acos_pkg;

   // operand widths
   localparam int X_W       = 15;          // |cosine| in Q.14, 0 to 16384
   localparam int ROOT_W    = 15;          // sqrt(1 - x) in Q.14
   localparam int REM_W     = ROOT_W + 3;  // square root partial remainder
   localparam int RAD_W     = 2 * ROOT_W;  // square root operand
   localparam int NUM_CELLS = ROOT_W;      // one root bit per cell
   localparam int A_W       = 17;
   localparam int B_W       = 18;
   localparam int P_W       = 21;
   localparam int R_W       = 22;
   localparam int D_W       = 16;

   // fixed-point constants
   localparam logic [X_W-1:0] ONE_Q14        = 15'd16384;
   localparam logic [P_W-1:0] C0_Q20         = 21'd1647029;
   localparam logic [B_W-1:0] C1_Q20         = 18'd222418;
   localparam logic [A_W-1:0] C2_Q20         = 17'd77868;
   localparam logic [14:0]    C3_Q20         = 15'd19639;
   localparam logic [R_W-1:0] DEG_PER_RAD    = 22'd3754936;
   localparam logic [D_W-1:0] HALF_TURN_Q8   = 16'd46080;

   // one square root cell's view of a transaction
   typedef struct packed {
      logic              valid;
      logic              neg;
      logic [X_W-1:0]    x;
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } acos_cell_type;

   // back end stages
   typedef struct packed {
      logic              valid;
      logic              neg;
      logic [X_W-1:0]    x;
      logic [ROOT_W-1:0] s;
      logic [A_W-1:0]    a;
   } acos_sta_type;

   typedef struct packed {
      logic              valid;
      logic              neg;
      logic [X_W-1:0]    x;
      logic [ROOT_W-1:0] s;
      logic [B_W-1:0]    b;
   } acos_stb_type;

   typedef struct packed {
      logic              valid;
      logic              neg;
      logic [ROOT_W-1:0] s;
      logic [P_W-1:0]    p;
   } acos_stp_type;

   typedef struct packed {
      logic           valid;
      logic           neg;
      logic [R_W-1:0] r;
   } acos_str_type;

   typedef struct packed {
      logic           valid;
      logic           neg;
      logic [D_W-1:0] d;
   } acos_std_type;

   typedef struct packed {
      logic           valid;
      logic [D_W-1:0] angle;
   } acos_sto_type;

endpackage

>>> hw/rtl/acos_cell.sv
// one square root cell: settles one root bit and passes the transaction on
module acos_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  acos_pkg::acos_cell_type prev_cell,
   output acos_pkg::acos_cell_type this_cell
);
   import acos_pkg::*;

   acos_cell_type     cell_ff;
   acos_cell_type     cell_in;
   logic [REM_W-1:0]  rem_shift;
   logic [REM_W-1:0]  trial;

   // bring down the next bit pair and try the next root bit
   always_comb begin
      rem_shift = {prev_cell.rem[REM_W-3:0], prev_cell.rad[RAD_W-1 -: 2]};
      trial     = {1'b0, prev_cell.root, 2'b01};
      cell_in   = prev_cell;
      cell_in.rad = {prev_cell.rad[RAD_W-3:0], 2'b00};
      if (rem_shift >= trial) begin
         cell_in.rem  = rem_shift - trial;
         cell_in.root = {prev_cell.root[ROOT_W-2:0], 1'b1};
      end else begin
         cell_in.rem  = rem_shift;
         cell_in.root = {prev_cell.root[ROOT_W-2:0], 1'b0};
      end
   end

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (advance) begin
         cell_ff.valid <= cell_in.valid;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (advance) begin
         cell_ff.neg  <= cell_in.neg;
         cell_ff.x    <= cell_in.x;
         cell_ff.rad  <= cell_in.rad;
         cell_ff.rem  <= cell_in.rem;
         cell_ff.root <= cell_in.root;
      end
   end

   assign this_cell = cell_ff;

endmodule

>>> hw/rtl/acos_back.sv
// polynomial, scaling and sign fold stages after the square root cells
module acos_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  acos_pkg::acos_cell_type root_cell,
   output logic                    out_valid,
   output logic [acos_pkg::D_W-1:0] out_angle
);
   import acos_pkg::*;

   acos_sta_type sta_ff, sta_in;
   acos_stb_type stb_ff, stb_in;
   acos_stp_type stp_ff, stp_in;
   acos_str_type str_ff, str_in;
   acos_std_type std_ff, std_in;
   acos_sto_type sto_ff, sto_in;

   logic [29:0] prod_a;
   logic [31:0] prod_b;
   logic [32:0] prod_p;
   logic [35:0] prod_r;
   logic [43:0] prod_d;

   // horner step: a = c2 - c3*x
   always_comb begin
      prod_a       = {15'b0, C3_Q20} * {15'b0, root_cell.x};
      sta_in.valid = root_cell.valid;
      sta_in.neg   = root_cell.neg;
      sta_in.x     = root_cell.x;
      sta_in.s     = root_cell.root;
      sta_in.a     = C2_Q20 - {1'b0, prod_a[29:14]};
   end

   // horner step: b = c1 - a*x
   always_comb begin
      prod_b       = {15'b0, sta_ff.a} * {17'b0, sta_ff.x};
      stb_in.valid = sta_ff.valid;
      stb_in.neg   = sta_ff.neg;
      stb_in.x     = sta_ff.x;
      stb_in.s     = sta_ff.s;
      stb_in.b     = C1_Q20 - prod_b[31:14];
   end

   // horner step: p = c0 - b*x
   always_comb begin
      prod_p       = {15'b0, stb_ff.b} * {18'b0, stb_ff.x};
      stp_in.valid = stb_ff.valid;
      stp_in.neg   = stb_ff.neg;
      stp_in.s     = stb_ff.s;
      stp_in.p     = C0_Q20 - {2'b0, prod_p[32:14]};
   end

   // angle in radians
   always_comb begin
      prod_r       = {15'b0, stp_ff.p} * {21'b0, stp_ff.s};
      str_in.valid = stp_ff.valid;
      str_in.neg   = stp_ff.neg;
      str_in.r     = prod_r[35:14];
   end

   // radians to degrees
   always_comb begin
      prod_d       = {22'b0, str_ff.r} * {22'b0, DEG_PER_RAD};
      std_in.valid = str_ff.valid;
      std_in.neg   = str_ff.neg;
      std_in.d     = prod_d[43:28];
   end

   // negative cosine folds to the far half turn
   always_comb begin
      sto_in.valid = std_ff.valid;
      sto_in.angle = std_ff.neg ? (HALF_TURN_Q8 - std_ff.d) : std_ff.d;
   end

   // stage valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         sta_ff.valid <= 1'b0;
         stb_ff.valid <= 1'b0;
         stp_ff.valid <= 1'b0;
         str_ff.valid <= 1'b0;
         std_ff.valid <= 1'b0;
         sto_ff.valid <= 1'b0;
      end else if (advance) begin
         sta_ff.valid <= sta_in.valid;
         stb_ff.valid <= stb_in.valid;
         stp_ff.valid <= stp_in.valid;
         str_ff.valid <= str_in.valid;
         std_ff.valid <= std_in.valid;
         sto_ff.valid <= sto_in.valid;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (advance) begin
         sta_ff.neg   <= sta_in.neg;
         sta_ff.x     <= sta_in.x;
         sta_ff.s     <= sta_in.s;
         sta_ff.a     <= sta_in.a;
         stb_ff.neg   <= stb_in.neg;
         stb_ff.x     <= stb_in.x;
         stb_ff.s     <= stb_in.s;
         stb_ff.b     <= stb_in.b;
         stp_ff.neg   <= stp_in.neg;
         stp_ff.s     <= stp_in.s;
         stp_ff.p     <= stp_in.p;
         str_ff.neg   <= str_in.neg;
         str_ff.r     <= str_in.r;
         std_ff.neg   <= std_in.neg;
         std_ff.d     <= std_in.d;
         sto_ff.angle <= sto_in.angle;
      end
   end

   assign out_valid = sto_ff.valid;
   assign out_angle = sto_ff.angle;

endmodule

>>> hw/rtl/arccos_polynomial_approx.sv
// arc cosine unit: square root cell chain followed by polynomial back end
//
//   channel | direction | ports                          | payload
//   req     | in        | req_valid, req_ready           | req_cosine, signed Q2.14
//   rsp     | out       | rsp_valid, rsp_ready           | rsp_angle_degrees, Q8.8
//
// one transaction per cycle while no result is held; rsp_valid rises once the transaction
// has passed the 15 square root cells (one root bit each) and 6 back end stages,
// 21 registers in all with the first loaded at the accepting edge.
// synchronous active high reset clears only the valid flags.
// a held result (rsp_valid high, rsp_ready low) freezes the whole pipeline,
// and req_ready drops for those cycles.
module arccos_polynomial_approx (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_cosine,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_angle_degrees
);
   import acos_pkg::*;

   logic          advance;
   logic          neg;
   logic [16:0]   mag;
   logic [X_W-1:0] x_sat;
   acos_cell_type link [NUM_CELLS+1];

   // the pipeline moves whenever the output register is free or drained
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // fold the cosine to a saturated magnitude
   always_comb begin
      neg   = req_cosine[15];
      mag   = neg ? (17'h10000 - {1'b0, req_cosine}) : {1'b0, req_cosine};
      x_sat = (mag > {2'b0, ONE_Q14}) ? ONE_Q14 : mag[X_W-1:0];
      link[0].valid = req_valid;
      link[0].neg   = neg;
      link[0].x     = x_sat;
      link[0].rad   = {1'b0, ONE_Q14 - x_sat, 14'b0};
      link[0].rem   = '0;
      link[0].root  = '0;
   end

   // square root chain
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      acos_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .prev_cell (link[i]),
         .this_cell (link[i+1])
      );
   end

   // polynomial and scaling
   acos_back u_back (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .root_cell (link[NUM_CELLS]),
      .out_valid (rsp_valid),
      .out_angle (rsp_angle_degrees)
   );

`ifndef SYNTHESIS
   // results never pass a half turn
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_angle_degrees <= HALF_TURN_Q8)
      else $error("angle above 180 degrees");

   // first cell only ever holds a saturated magnitude
   a_x_sat: assert property (@(posedge clock) disable iff (reset)
      link[1].valid |-> link[1].x <= ONE_Q14)
      else $error("magnitude not saturated");

   // finished root leaves a remainder no larger than twice the root
   a_root_rem: assert property (@(posedge clock) disable iff (reset)
      link[NUM_CELLS].valid |->
         link[NUM_CELLS].rem <= {2'b0, link[NUM_CELLS].root, 1'b0})
      else $error("square root remainder out of bound");

   // an accepted transaction lands in the first cell
   a_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> link[1].valid)
      else $error("accepted transaction lost at the first cell");
`endif

endmodule

>>> tb/arccos_polynomial_approx_test.sv
// testbench for the arc cosine unit: directed and random cosines, scoreboard against a predictor
`timescale 1ns / 1ps

// scoreboard: predicts the angle of each accepted cosine and compares results in order
class arccos_scoreboard;
   localparam longint unsigned ONE_Q14      = 16384;
   localparam longint unsigned C0_Q20       = 1647029;
   localparam longint unsigned C1_Q20       = 222418;
   localparam longint unsigned C2_Q20       = 77868;
   localparam longint unsigned C3_Q20       = 19639;
   localparam longint unsigned DEG_PER_RAD  = 3754936;
   localparam longint unsigned HALF_TURN_Q8 = 46080;

   typedef struct {
      logic [15:0] cosine;
      logic [15:0] angle;
   } angle_entry_type;

   angle_entry_type angle_queue[$];
   int           mismatches;
   int           angles_checked;
   int           cosines_seen;
   int           cosines_clipped;
   int           cosines_negative;

   // floor of the square root, one result bit per pass
   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned rem   = v;
      longint unsigned root  = 0;
      longint unsigned probe = 64'd1 << 30;
      while (probe > rem)
         probe = probe >> 2;
      while (probe != 0) begin
         if (rem >= root + probe) begin
            rem  = rem - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   // arc cosine of a Q2.14 cosine in Q8.8 degrees
   function automatic logic [15:0] arccos_q8_8(logic [15:0] cosine);
      logic            neg;
      longint unsigned mag;
      longint unsigned a;
      longint unsigned b;
      longint unsigned p;
      longint unsigned s;
      longint unsigned r;
      longint unsigned d;
      neg = cosine[15];
      mag = neg ? (64'h10000 - cosine) : cosine;
      // magnitudes beyond 1.0 clip to 1.0
      if (mag > ONE_Q14)
         mag = ONE_Q14;
      // horner evaluation of the cubic
      a = C2_Q20 - ((C3_Q20 * mag) >> 14);
      b = C1_Q20 - ((a * mag) >> 14);
      p = C0_Q20 - ((b * mag) >> 14);
      s = floor_sqrt((ONE_Q14 - mag) << 14);
      r = (p * s) >> 14;
      d = (r * DEG_PER_RAD) >> 28;
      // negative cosine folds back from 180 degrees
      if (neg)
         d = HALF_TURN_Q8 - d;
      return d[15:0];
   endfunction

   function void note_cosine(logic [15:0] cosine);
      angle_entry_type entry;
      entry.cosine = cosine;
      entry.angle  = arccos_q8_8(cosine);
      angle_queue.push_back(entry);
      cosines_seen++;
      if (cosine[15])
         cosines_negative++;
      if ($signed(cosine) > 16384 || $signed(cosine) < -16384)
         cosines_clipped++;
   endfunction

   function void check_angle(logic [15:0] angle);
      angle_entry_type entry;
      if (angle_queue.size() == 0) begin
         $display("%0t ns: unexpected angle %0d with no transaction outstanding",
                  $time, angle);
         mismatches++;
         return;
      end
      entry = angle_queue.pop_front();
      angles_checked++;
      if (angle !== entry.angle) begin
         $display("%0t ns: angle mismatch for cosine %0d: expected %0d, actual %0d",
                  $time, $signed(entry.cosine), entry.angle, angle);
         mismatches++;
      end
   endfunction

   function int pending();
      return angle_queue.size();
   endfunction
endclass

module arccos_polynomial_approx_test;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 40;
   localparam int PHASE_ITEMS  = 275;

   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        req_valid         = 1'b0;
   logic        req_ready;
   logic [15:0] req_cosine        = 16'd0;
   logic        rsp_valid;
   logic        rsp_ready         = 1'b0;
   logic [15:0] rsp_angle_degrees;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int cycle_count    = 0;

   arccos_scoreboard board = new;

   arccos_polynomial_approx dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cosine        (req_cosine),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_angle_degrees (rsp_angle_degrees)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // run time limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d angles outstanding",
                  cycle_count, board.pending());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // receiver backpressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // transaction monitor on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            board.note_cosine(req_cosine);
         if (rsp_valid && rsp_ready)
            board.check_angle(rsp_angle_degrees);
      end
   end

   // present one cosine and hold it until accepted
   task automatic send_cosine(input logic [15:0] cosine);
      if (send_idle_pct != 0) begin
         while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid  <= 1'b1;
      req_cosine <= cosine;
      do
         @(posedge clock);
      while (!req_ready);
   endtask

   // random cosine: mostly in range, some near the ends, some raw 16-bit
   task automatic send_random_cosine();
      int          pick;
      int          value;
      pick = $urandom_range(99);
      if (pick < 80)
         value = int'($urandom_range(32768)) - 16384;
      else if (pick < 90)
         value = ($urandom_range(1) ? 16384 : -16384) + int'($urandom_range(16)) - 8;
      else
         value = int'($urandom_range(65535));
      send_cosine(value[15:0]);
   endtask

   initial begin
      logic [15:0] corner_cosines[] = '{
         16'd0, 16'd1, -16'sd1, 16'd2, -16'sd2, 16'd16384, -16'sd16384, 16'd16383,
         -16'sd16383, 16'd16385, -16'sd16385, 16'h7FFF, 16'h8000, 16'd8192,
         -16'sd8192, 16'd11585, -16'sd11585, 16'h5555, 16'hAAAA, 16'h00FF,
         16'hFF00, 16'd100, -16'sd100
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corner cosines back to back, no idling
      foreach (corner_cosines[i])
         send_cosine(corner_cosines[i]);

      // random phases with different idling
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
            default: begin send_idle_pct = 29; recv_stall_pct = 29; end
         endcase
         repeat (PHASE_ITEMS)
            send_random_cosine();
      end
      req_valid <= 1'b0;
      recv_stall_pct = 0;

      // drain
      while (board.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d cosines (%0d negative, %0d beyond +/-1.0) under four idling mixes",
               board.cosines_seen, board.cosines_negative, board.cosines_clipped);
      $display("compared %0d angles, %0d mismatches", board.angles_checked,
               board.mismatches);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
